[sv/esl_pkg.sv]
// esl_pkg: shared types and constants for the slew limited pulse generator
package esl_pkg;

	localparam int PULSE_FRAC_BITS = 8;
	localparam int TIME_BITS       = 32;
	localparam int POWER_FRAC_BITS = 14;
	localparam int PWR_SHIFT       = POWER_FRAC_BITS - PULSE_FRAC_BITS;

	localparam int US_W    = 12;
	localparam int PULSE_W = US_W + PULSE_FRAC_BITS;
	localparam int POWER_W = 16;
	localparam int RATE_W  = 16;
	localparam int DZ_W    = 10;
	localparam int STEP_W  = RATE_W + TIME_BITS;

	typedef logic [PULSE_W-1:0]          pulse_t;
	typedef logic signed [POWER_W-1:0]   power_t;
	typedef logic [TIME_BITS-1:0]        time_t;

	typedef logic [1:0] op_t;
	localparam op_t OP_SET  = 2'd0;
	localparam op_t OP_ADD  = 2'd1;
	localparam op_t OP_TICK = 2'd2;

	localparam logic [1:0] CFG_NEUTRAL  = 2'd0;
	localparam logic [1:0] CFG_SPAN     = 2'd1;
	localparam logic [1:0] CFG_RATE     = 2'd2;
	localparam logic [1:0] CFG_DEADZONE = 2'd3;

	localparam logic signed [POWER_W:0] POWER_ONE = (POWER_W+1)'(1) <<< POWER_FRAC_BITS;
	localparam pulse_t PULSE_MAX = '1;

	localparam logic [US_W-1:0]   NEUTRAL_RST  = 12'd1500;
	localparam logic [US_W-1:0]   SPAN_RST     = 12'd500;
	localparam logic [RATE_W-1:0] RATE_RST     = 16'd256;
	localparam logic [DZ_W-1:0]   DEADZONE_RST = 10'd0;
	localparam pulse_t PULSE_RST = {NEUTRAL_RST, {PULSE_FRAC_BITS{1'b0}}};

	typedef struct packed {
		logic [US_W-1:0]   neutral_pulse;
		logic [US_W-1:0]   pulse_span;
		logic [RATE_W-1:0] max_rate;
		logic [DZ_W-1:0]   deadzone_width;
	} cfg_t;

endpackage

[sv/esl_cfg.sv]
// esl_cfg: configuration register file
module esl_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_addr,
	input  logic [15:0]       cfg_wdata,
	output esl_pkg::cfg_t     cfg
);

	esl_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.neutral_pulse  <= esl_pkg::NEUTRAL_RST;
			cfg_q.pulse_span     <= esl_pkg::SPAN_RST;
			cfg_q.max_rate       <= esl_pkg::RATE_RST;
			cfg_q.deadzone_width <= esl_pkg::DEADZONE_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				esl_pkg::CFG_NEUTRAL:  cfg_q.neutral_pulse  <= cfg_wdata[esl_pkg::US_W-1:0];
				esl_pkg::CFG_SPAN:     cfg_q.pulse_span     <= cfg_wdata[esl_pkg::US_W-1:0];
				esl_pkg::CFG_RATE:     cfg_q.max_rate       <= cfg_wdata[esl_pkg::RATE_W-1:0];
				esl_pkg::CFG_DEADZONE: cfg_q.deadzone_width <= cfg_wdata[esl_pkg::DZ_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[sv/esl_target.sv]
// esl_target: power clamp and mapping of power to the target pulse
module esl_target (
	input  logic              add_en,
	input  esl_pkg::power_t   power_value,
	input  esl_pkg::power_t   power_q,
	input  esl_pkg::cfg_t     cfg,
	output esl_pkg::power_t   power_new,
	output esl_pkg::pulse_t   target_new
);

	localparam int PROD_W = esl_pkg::US_W + 1 + esl_pkg::POWER_W;
	localparam int SUM_W  = esl_pkg::PULSE_W + 4;

	logic signed [esl_pkg::POWER_W:0] sum;
	logic signed [PROD_W-1:0]         prod;
	logic signed [PROD_W-1:0]         scaled;
	logic signed [SUM_W-1:0]          total;

	always_comb begin
		if (add_en) begin
			sum = (esl_pkg::POWER_W+1)'(power_q) + (esl_pkg::POWER_W+1)'(power_value);
		end else begin
			sum = (esl_pkg::POWER_W+1)'(power_value);
		end
		// clamp to plus or minus one
		if (sum > esl_pkg::POWER_ONE) begin
			power_new = esl_pkg::POWER_W'(esl_pkg::POWER_ONE);
		end else if (sum < -esl_pkg::POWER_ONE) begin
			power_new = esl_pkg::POWER_W'(-esl_pkg::POWER_ONE);
		end else begin
			power_new = sum[esl_pkg::POWER_W-1:0];
		end
		prod   = $signed({1'b0, cfg.pulse_span}) * power_new;
		// arithmetic shift rounds toward minus infinity
		scaled = prod >>> esl_pkg::PWR_SHIFT;
		total  = $signed({4'b0, cfg.neutral_pulse, {esl_pkg::PULSE_FRAC_BITS{1'b0}}})
			+ $signed(scaled[SUM_W-1:0]);
		if (total < 0) begin
			target_new = '0;
		end else if (total > $signed({4'b0, esl_pkg::PULSE_MAX})) begin
			target_new = esl_pkg::PULSE_MAX;
		end else begin
			target_new = total[esl_pkg::PULSE_W-1:0];
		end
	end

endmodule

[sv/esl_slew.sv]
// esl_slew: slew step toward the target and deadzone kick for one tick
module esl_slew (
	input  esl_pkg::time_t    timestamp,
	input  esl_pkg::time_t    last_time,
	input  esl_pkg::pulse_t   current,
	input  esl_pkg::pulse_t   target,
	input  esl_pkg::cfg_t     cfg,
	output esl_pkg::pulse_t   current_new
);

	localparam int PW = esl_pkg::PULSE_W;

	esl_pkg::time_t               dt;
	logic [esl_pkg::STEP_W-1:0]   step;
	logic                         up;
	esl_pkg::pulse_t              ds;
	logic                         short_step;
	esl_pkg::pulse_t              moved;
	esl_pkg::pulse_t              neu;
	esl_pkg::pulse_t              diff;
	logic [PW-1:0]                dz;
	logic [PW:0]                  kick_hi;
	logic signed [PW:0]           kick_lo;

	always_comb begin
		dt    = timestamp - last_time;
		step  = esl_pkg::STEP_W'(cfg.max_rate) * esl_pkg::STEP_W'(dt);
		up    = target > current;
		ds    = up ? target - current : current - target;
		short_step = (step[esl_pkg::STEP_W-1:PW] == '0) && (step[PW-1:0] < ds);
		if (!short_step) begin
			moved = target;
		end else if (up) begin
			moved = current + step[PW-1:0];
		end else begin
			moved = current - step[PW-1:0];
		end

		neu     = {cfg.neutral_pulse, {esl_pkg::PULSE_FRAC_BITS{1'b0}}};
		dz      = PW'({cfg.deadzone_width, {esl_pkg::PULSE_FRAC_BITS{1'b0}}});
		diff    = (moved > neu) ? moved - neu : neu - moved;
		kick_hi = {1'b0, neu} + {dz, 1'b0};
		kick_lo = $signed({1'b0, neu}) - $signed({dz, 1'b0});

		current_new = moved;
		if (dz > diff) begin
			if (target > neu) begin
				if ({1'b0, target} > kick_hi) begin
					current_new = kick_hi[PW-1:0];
				end
			end else if ($signed({1'b0, target}) < kick_lo) begin
				current_new = kick_lo[PW-1:0];
			end
		end
	end

endmodule

[sv/esc_slew_limiter_deadzone.sv]
// esc_slew_limiter_deadzone: top level of the slew limited esc pulse generator
//
// A word is taken in every cycle when the output side keeps up. Each word is
// registered, then handled by the target or slew logic, which updates the
// state at the edge that moves the word on, so a following word sees it at
// once. A tick loads its result word into the result register at that
// same edge; set and add give none. A tick held in the input stage while
// the result register is full and not being read stalls the input, so the
// rate falls to the rate at which results are taken.
module esc_slew_limiter_deadzone (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // power_value[15:0], timestamp[47:16]
	input  logic [1:0]  s_tuser,   // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // pulse_us[11:0], target_pulse_us[23:12]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [15:0] cfg_wdata
);

	localparam int PW = esl_pkg::PULSE_W;
	localparam int FB = esl_pkg::PULSE_FRAC_BITS;

	esl_pkg::cfg_t   cfg;

	logic            v_s1;
	esl_pkg::op_t    op_s1;
	esl_pkg::power_t power_s1;
	esl_pkg::time_t  ts_s1;

	esl_pkg::pulse_t current_q;
	esl_pkg::pulse_t target_q;
	esl_pkg::power_t power_q;
	esl_pkg::time_t  last_time_q;

	logic            out_valid_q;
	logic [23:0]     out_data_q;

	esl_pkg::power_t power_new;
	esl_pkg::pulse_t target_new;
	esl_pkg::pulse_t current_new;

	logic            is_tick;
	logic            out_free;
	logic            go;
	logic            take;

	esl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	esl_target u_target (
		.add_en      (op_s1 == esl_pkg::OP_ADD),
		.power_value (power_s1),
		.power_q     (power_q),
		.cfg         (cfg),
		.power_new   (power_new),
		.target_new  (target_new)
	);

	esl_slew u_slew (
		.timestamp   (ts_s1),
		.last_time   (last_time_q),
		.current     (current_q),
		.target      (target_q),
		.cfg         (cfg),
		.current_new (current_new)
	);

	assign is_tick  = op_s1 == esl_pkg::OP_TICK;
	assign out_free = !out_valid_q || m_tready;
	assign go       = v_s1 && (!is_tick || out_free);
	assign s_tready = !v_s1 || go;
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (go) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1    <= s_tuser;
			power_s1 <= s_tdata[15:0];
			ts_s1    <= s_tdata[47:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_q   <= esl_pkg::PULSE_RST;
			target_q    <= esl_pkg::PULSE_RST;
			power_q     <= '0;
			last_time_q <= '0;
		end else if (go) begin
			if (op_s1 == esl_pkg::OP_SET || op_s1 == esl_pkg::OP_ADD) begin
				power_q  <= power_new;
				target_q <= target_new;
			end else if (is_tick) begin
				last_time_q <= ts_s1;
				current_q   <= current_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && is_tick) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && is_tick) begin
			out_data_q <= {target_q[PW-1:FB], current_new[PW-1:FB]};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

[sv/esl_chk.sv]
// esl_chk: port level checks on the slew limited pulse generator
module esl_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	// held result word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// input never blocked while the result register is empty
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

	// no result without a recent word
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid && !(s_tvalid && s_tready) && !$past(s_tvalid && s_tready)
		|=> !m_tvalid)
		else $error("result word without an input word");

	// a word other than a tick taken into an empty pipe makes no result
	a_tick_only: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid && !$past(s_tvalid && s_tready) && s_tvalid && s_tready
		&& s_tuser != esl_pkg::OP_TICK ##1 !(s_tvalid && s_tready) |=> !m_tvalid)
		else $error("result word from a set or add");

endmodule

bind esc_slew_limiter_deadzone esl_chk u_esl_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[verif/esc_slew_limiter_deadzone_checker.sv]
// checker: predicts and compares the pulse words of esc_slew_limiter_deadzone
module esc_slew_limiter_deadzone_checker
	import esl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,   // power_value[15:0], timestamp[47:16]
	input  logic [1:0]  s_tuser,   // operation[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // pulse_us[11:0], target_pulse_us[23:12]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [15:0] cfg_wdata,
	output int          fail_count,
	output int          pending_count
);

	localparam int RATE_FRAC = 8;

	typedef struct packed {
		logic [US_W-1:0] target_us;
		logic [US_W-1:0] pulse_us;
	} pulse_word_t;

	cfg_t        regs;
	pulse_t      cur_pulse;
	pulse_t      tgt_pulse;
	power_t      power;
	time_t       last_ts;
	pulse_word_t pulse_q[$];
	int          n_fail = 0;

	function automatic pulse_t clip_pulse(longint v);
		if (v < 0)
			return '0;
		if (v > longint'(PULSE_MAX))
			return PULSE_MAX;
		return pulse_t'(v);
	endfunction

	function void clear_state();
		regs      = '{NEUTRAL_RST, SPAN_RST, RATE_RST, DEADZONE_RST};
		cur_pulse = PULSE_RST;
		tgt_pulse = PULSE_RST;
		power     = '0;
		last_ts   = '0;
	endfunction

	function void write_reg(logic [1:0] addr, logic [15:0] data);
		case (addr)
			CFG_NEUTRAL:  regs.neutral_pulse  = data[US_W-1:0];
			CFG_SPAN:     regs.pulse_span     = data[US_W-1:0];
			CFG_RATE:     regs.max_rate       = data[RATE_W-1:0];
			CFG_DEADZONE: regs.deadzone_width = data[DZ_W-1:0];
			default: ;
		endcase
	endfunction

	// clamp to plus or minus one, then map to the target pulse, floor rounded
	function void set_power(longint p);
		longint one;
		longint t;
		one = longint'(1) <<< POWER_FRAC_BITS;
		if (p > one)
			p = one;
		if (p < -one)
			p = -one;
		power     = power_t'(p);
		t         = (longint'(regs.pulse_span) * p) >>> PWR_SHIFT;
		tgt_pulse = clip_pulse((longint'(regs.neutral_pulse) <<< PULSE_FRAC_BITS) + t);
	endfunction

	function bit predict_pulse(op_t op, power_t pv, time_t ts, output pulse_word_t res);
		time_t  dt;
		longint step;
		longint c;
		longint g;
		longint delta;
		longint neu;
		longint dz;
		longint kick;
		res = '0;
		case (op)
			OP_SET: begin
				set_power(longint'(pv));
				return 1'b0;
			end
			OP_ADD: begin
				set_power(longint'(power) + longint'(pv));
				return 1'b0;
			end
			OP_TICK: begin
				dt      = ts - last_ts;
				last_ts = ts;
				step    = (longint'(regs.max_rate) * longint'(dt)) <<< (PULSE_FRAC_BITS - RATE_FRAC);
				c       = longint'(cur_pulse);
				g       = longint'(tgt_pulse);
				delta   = (g > c) ? g - c : c - g;
				if (step < delta)
					c = (g > c) ? c + step : c - step;
				else
					c = g;
				neu = longint'(regs.neutral_pulse) <<< PULSE_FRAC_BITS;
				dz  = longint'(regs.deadzone_width) <<< PULSE_FRAC_BITS;
				// inside the deadzone, kick out to twice its width when the target is past it
				if (dz > ((c > neu) ? c - neu : neu - c)) begin
					if (g > neu) begin
						kick = neu + 2 * dz;
						if (g > kick)
							c = kick;
					end else begin
						kick = neu - 2 * dz;
						if (g < kick)
							c = kick;
					end
				end
				cur_pulse     = clip_pulse(c);
				res.pulse_us  = cur_pulse[PULSE_W-1 -: US_W];
				res.target_us = tgt_pulse[PULSE_W-1 -: US_W];
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin : scoreboard
		pulse_word_t want;
		pulse_word_t got;
		if (!arst_n) begin
			clear_state();
			pulse_q.delete();
			pending_count <= 0;
			fail_count    <= n_fail;
		end else begin
			if (cfg_we)
				write_reg(cfg_addr, cfg_wdata);
			if (s_tvalid && s_tready) begin
				if (predict_pulse(op_t'(s_tuser), power_t'(s_tdata[15:0]), time_t'(s_tdata[47:16]),
						want))
					pulse_q.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				got = pulse_word_t'(m_tdata);
				if (pulse_q.size() == 0) begin
					$error("unexpected word: pulse_us %0d target_pulse_us %0d",
						got.pulse_us, got.target_us);
					n_fail++;
				end else begin
					want = pulse_q.pop_front();
					if (got.pulse_us !== want.pulse_us) begin
						$error("pulse_us: expected %0d, actual %0d", want.pulse_us, got.pulse_us);
						n_fail++;
					end
					if (got.target_us !== want.target_us) begin
						$error("target_pulse_us: expected %0d, actual %0d",
							want.target_us, got.target_us);
						n_fail++;
					end
				end
			end
			pending_count <= pulse_q.size();
			fail_count    <= n_fail;
		end
	end

endmodule

[verif/esc_slew_limiter_deadzone_test.sv]
// testbench top: stimulus, handshake pacing and verdict for esc_slew_limiter_deadzone
module esc_slew_limiter_deadzone_test;
	import esl_pkg::*;

	localparam int  CYCLE_LIMIT  = 1000000;
	localparam int  LONG_HOLD    = 400;
	localparam int  FLUSH_CYCLES = 4;
	localparam int  PHASES       = 10;
	localparam int  PHASE_WORDS  = 200;
	localparam op_t OP_NONE      = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // power_value[15:0], timestamp[47:16]
	logic [1:0]  s_tuser;   // operation[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // pulse_us[11:0], target_pulse_us[23:12]
	logic        cfg_we;
	logic [1:0]  cfg_addr;
	logic [15:0] cfg_wdata;

	int     fail_count;
	int     pending_count;
	longint cycles = 0;
	bit     tx_idle;
	bit     rx_idle;
	bit     rx_hold;
	time_t  now_ts;

	esc_slew_limiter_deadzone u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	esc_slew_limiter_deadzone_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("esc_slew_limiter_deadzone regression: fail");
			$finish;
		end
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin : pulse_sink
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = rx_idle ? $urandom_range(0, 17) : 0;
			if (rx_hold) begin
				stall  += LONG_HOLD;
				rx_hold = 1'b0;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	task automatic send_word(op_t op, power_t pv, time_t ts);
		int gap;
		gap = tx_idle ? $urandom_range(0, 17) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {ts, pv};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic tick_at(time_t ts);
		now_ts = ts;
		send_word(OP_TICK, power_t'($urandom), ts);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (FLUSH_CYCLES) @(posedge clk);
	endtask

	task automatic load_regs(logic [11:0] neutral, logic [11:0] span, logic [15:0] rate,
			logic [9:0] dz);
		cfg_we    <= 1'b1;
		cfg_addr  <= CFG_NEUTRAL;
		cfg_wdata <= 16'(neutral);
		@(posedge clk);
		cfg_addr  <= CFG_SPAN;
		cfg_wdata <= 16'(span);
		@(posedge clk);
		cfg_addr  <= CFG_RATE;
		cfg_wdata <= rate;
		@(posedge clk);
		cfg_addr  <= CFG_DEADZONE;
		cfg_wdata <= 16'(dz);
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic power_t draw_power();
		int v;
		case ($urandom_range(0, 5))
			0: begin
				case ($urandom_range(0, 4))
					0: v = 16384;
					1: v = -16384;
					2: v = 32767;
					3: v = -32768;
					default: v = 0;
				endcase
			end
			1, 2: v = $urandom_range(0, 32768) - 16384;
			3: v = $urandom_range(0, 400) - 200;
			default: v = $urandom_range(0, 65535);
		endcase
		return power_t'(v);
	endfunction

	function automatic time_t draw_time();
		case ($urandom_range(0, 9))
			0: return time_t'($urandom);
			1: return now_ts;
			2, 3: return now_ts + time_t'($urandom_range(1, 2000));
			default: return now_ts + time_t'($urandom_range(1, 40));
		endcase
	endfunction

	task automatic load_phase_regs(int p);
		logic [11:0] neutral;
		logic [11:0] span;
		logic [15:0] rate;
		logic [9:0]  dz;
		case (p)
			0: load_regs(12'd0, 12'd4095, 16'd1, 10'd1023);
			1: load_regs(12'd4095, 12'd4095, 16'd0, 10'd0);
			2: load_regs(12'd1500, 12'd500, 16'd65535, 10'd1023);
			3: load_regs(12'd2048, 12'd0, 16'd16, 10'd50);
			default: begin
				case ($urandom_range(0, 3))
					0: neutral = 12'd0;
					1: neutral = 12'd4095;
					default: neutral = 12'($urandom_range(0, 4095));
				endcase
				case ($urandom_range(0, 3))
					0: span = 12'd0;
					1: span = 12'd4095;
					default: span = 12'($urandom_range(0, 4095));
				endcase
				case ($urandom_range(0, 4))
					0: rate = 16'd0;
					1: rate = 16'hffff;
					2: rate = 16'($urandom);
					default: rate = 16'($urandom_range(1, 600));
				endcase
				case ($urandom_range(0, 3))
					0: dz = 10'd0;
					1: dz = 10'd1023;
					default: dz = 10'($urandom_range(0, 300));
				endcase
				load_regs(neutral, span, rate, dz);
			end
		endcase
	endtask

	initial begin : stimulus
		int r;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = OP_SET;
		cfg_we    = 1'b0;
		cfg_addr  = CFG_NEUTRAL;
		cfg_wdata = '0;
		tx_idle   = 1'b1;
		rx_idle   = 1'b1;
		rx_hold   = 1'b0;
		now_ts    = '0;
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// reset settings: slew, clamps, floor rounding, wrap, zero elapsed time
		tick_at(32'd0);
		send_word(OP_SET, 16'sd16384, '0);
		tick_at(32'd100);
		tick_at(32'd100);
		send_word(OP_SET, 16'sh7fff, '0);
		send_word(OP_ADD, 16'sh8000, '0);
		send_word(OP_ADD, 16'sh8000, '0);
		tick_at(32'hffff_fff0);
		send_word(OP_SET, -16'sd1, '0);
		tick_at(32'h0000_0010);
		send_word(OP_NONE, 16'hffff, 32'hffff_ffff);
		tick_at(32'h0000_0011);
		send_word(OP_ADD, 16'sh7fff, '0);
		tick_at(32'h0000_1000);
		drain();

		// deadzone kick on both sides and no kick when the target is short of it
		load_regs(12'd1500, 12'd500, 16'd256, 10'd100);
		send_word(OP_SET, 16'sd0, '0);
		tick_at(now_ts + 10000);
		send_word(OP_SET, 16'sd8192, '0);
		tick_at(now_ts + 1);
		send_word(OP_SET, 16'sd100, '0);
		tick_at(now_ts + 1000);
		send_word(OP_SET, -16'sd8192, '0);
		tick_at(now_ts + 1);
		drain();

		// saturation; the neutral write leaves the stored target alone
		load_regs(12'd4095, 12'd4095, 16'hffff, 10'd1023);
		tick_at(now_ts + 1);
		send_word(OP_SET, 16'sd16384, '0);
		tick_at(now_ts + 1);
		send_word(OP_SET, 16'sh8000, '0);
		tick_at(now_ts + 1);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			load_phase_regs(p);
			tx_idle = (p != 1) && (p != 2);
			rx_idle = (p != 1);
			if (p == 2)
				rx_hold = 1'b1;
			for (int i = 0; i < PHASE_WORDS; i++) begin
				if (i % 50 == 49) begin
					tx_idle = $urandom_range(0, 3) != 0;
					rx_idle = $urandom_range(0, 3) != 0;
				end
				r = $urandom_range(0, 99);
				if (r < 45)
					tick_at(draw_time());
				else if (r < 70)
					send_word(OP_SET, draw_power(), time_t'($urandom));
				else if (r < 93)
					send_word(OP_ADD, draw_power(), time_t'($urandom));
				else
					send_word(OP_NONE, power_t'($urandom), time_t'($urandom));
			end
			drain();
		end

		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("esc_slew_limiter_deadzone regression: pass");
		else
			$display("esc_slew_limiter_deadzone regression: fail");
		$finish;
	end

endmodule

[sim.f]
sv/esl_pkg.sv
sv/esl_cfg.sv
sv/esl_target.sv
sv/esl_slew.sv
sv/esc_slew_limiter_deadzone.sv
sv/esl_chk.sv
verif/esc_slew_limiter_deadzone_checker.sv
verif/esc_slew_limiter_deadzone_test.sv
